>>> src/akd_pkg.sv
// Shared constants and types for the analog ladder keypad decoder.
`default_nettype none

package akd_pkg;

    // Ladder geometry
    localparam int ADC_RANGE = 1024;
    localparam int KEY_COUNT = 14;

    // Field and state widths
    localparam int SAMPLE_W = 10;
    localparam int LVL_W    = 4;
    localparam int CNT_W    = 3;
    localparam int TGT_W    = 3;
    localparam int STAT_W   = 2;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 1;

    // Quantizer: (s + ADC_RANGE/28) / (ADC_RANGE/14) by reciprocal multiply.
    // With 24 fraction bits and a rounded-up reciprocal, the quotient is exact
    // for every biased sample below 2^11 and every divisor below 2^13.
    localparam int Q_BIAS  = ADC_RANGE / 28;
    localparam int Q_DIV   = ADC_RANGE / 14;
    localparam int Q_SHIFT = 24;
    localparam int Q_MULT  = ((1 << Q_SHIFT) + Q_DIV - 1) / Q_DIV;
    localparam int X_W     = SAMPLE_W + 1;
    localparam int PROD_W  = 32;

    // Special levels
    localparam logic [LVL_W-1:0] LVL_THREE = 4'd3;
    localparam logic [LVL_W-1:0] LVL_FIX   = 4'd5;
    localparam logic [LVL_W-1:0] LVL_MAX   = 4'd15;
    localparam logic [LVL_W-1:0] LVL_KEYS  = LVL_W'(KEY_COUNT);

    // Match counter ceiling
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_TARGET  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIX_THRESHOLD = 1'd1;

    // Register reset values
    localparam logic [TGT_W-1:0]    MATCH_TARGET_RST  = 3'd5;
    localparam logic [SAMPLE_W-1:0] FIX_THRESHOLD_RST = 10'd232;

    // Reported press status codes
    localparam logic [STAT_W-1:0] PS_NONE  = 2'd0;
    localparam logic [STAT_W-1:0] PS_TOUCH = 2'd1;
    localparam logic [STAT_W-1:0] PS_PRESS = 2'd2;

    // Touch/press machine
    typedef enum logic [2:0] {
        ST_NONE  = 3'b001,
        ST_TOUCH = 3'b010,
        ST_PRESS = 3'b100
    } t_touch;

endpackage

`default_nettype wire

>>> src/analog_ladder_keypad_decoder_unit.sv
// Top level of the analog ladder keypad decoder.
//
// Input channel: i_valid / o_stall with i_adc_sample, one raw conversion of
// the ladder per transfer. Output channel: o_valid / i_stall with
// o_key_valid, o_key_index and o_press_status, one transfer per debounced
// decision; samples that take no decision produce nothing.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 match target, 1 fix threshold) at the clock edge; write only while idle.
// Pipeline: a sample is captured in the input register and its decision in
// the result register. Throughput: one sample per cycle while o_stall is low;
// the level, debounce and touch machine step sit combinationally between the
// input register and the result register.
// Reset (synchronous, i_rst_n low): both registers return to 5 and 232,
// candidate level, match count and touch state clear, both stages empty.
// Receiver stall: the result register holds. Samples that take no decision
// still flow; the next sample that would decide waits in the input register
// and o_stall rises until the result register frees.
`default_nettype none

module analog_ladder_keypad_decoder_unit
    import akd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // sample channel
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [SAMPLE_W-1:0]  i_adc_sample,
    // result channel
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_key_valid,
    output logic      [LVL_W-1:0]     o_key_index,
    output logic      [STAT_W-1:0]    o_press_status
);

    // Configuration registers
    logic [TGT_W-1:0]    r_match_target;
    logic [SAMPLE_W-1:0] r_fix_threshold;

    // Input stage
    logic                r_s1_valid;
    logic [SAMPLE_W-1:0] r_s1_sample;

    // Debounce and machine state
    logic [LVL_W-1:0] r_cand;
    logic [CNT_W-1:0] r_cnt;
    t_touch           r_state;

    // Result stage
    logic              r_out_valid;
    logic              r_out_key_valid;
    logic [LVL_W-1:0]  r_out_key_index;
    logic [STAT_W-1:0] r_out_status;

    // Next values
    logic [LVL_W-1:0]  n_cand;
    logic [CNT_W-1:0]  n_cnt;
    t_touch            n_state;
    logic              n_key_valid;
    logic [LVL_W-1:0]  n_key_index;
    logic [STAT_W-1:0] n_status;

    logic [LVL_W-1:0] w_level;
    logic             w_decide;
    logic             w_out_free;
    logic             w_s1_fire;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_target  <= MATCH_TARGET_RST;
            r_fix_threshold <= FIX_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MATCH_TARGET:  r_match_target  <= i_cfg_data[TGT_W-1:0];
                REG_FIX_THRESHOLD: r_fix_threshold <= i_cfg_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    akd_quantizer u_quant (
        .i_sample        (r_s1_sample),
        .i_fix_threshold (r_fix_threshold),
        .o_level         (w_level)
    );

    // Debounce the level and step the touch machine on a decision
    always_comb begin
        if (w_level == r_cand) begin
            n_cand = r_cand;
            n_cnt  = (r_cnt == CNT_MAX) ? CNT_MAX : r_cnt + 1'b1;
        end else begin
            n_cand = w_level;
            n_cnt  = '0;
        end
        w_decide = (n_cnt >= r_match_target);

        n_key_valid = 1'b0;
        n_key_index = '0;
        case (r_state)
            ST_TOUCH: begin
                n_state = (n_cand < LVL_KEYS) ? ST_PRESS : ST_NONE;
            end
            ST_PRESS: begin
                if (n_cand < LVL_KEYS) begin
                    n_state     = ST_PRESS;
                    n_key_valid = 1'b1;
                    n_key_index = n_cand;
                end else begin
                    n_state = ST_NONE;
                end
            end
            default: begin
                n_state = ST_TOUCH;
            end
        endcase

        case (n_state)
            ST_TOUCH: n_status = PS_TOUCH;
            ST_PRESS: n_status = PS_PRESS;
            default:  n_status = PS_NONE;
        endcase
    end

    // Advance the input stage unless its decision has nowhere to go
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_s1_fire  = r_s1_valid && (!w_decide || w_out_free);
    assign o_stall    = r_s1_valid && !w_s1_fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_stall) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_s1_sample <= i_adc_sample;
        end
    end

    // Debounce state and machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand  <= '0;
            r_cnt   <= '0;
            r_state <= ST_NONE;
        end else if (w_s1_fire) begin
            if (w_decide) begin
                r_cand  <= '0;
                r_cnt   <= '0;
                r_state <= n_state;
            end else begin
                r_cand <= n_cand;
                r_cnt  <= n_cnt;
            end
        end
    end

    // Result register: load a decision, drop after transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_fire && w_decide) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire && w_decide) begin
            r_out_key_valid <= n_key_valid;
            r_out_key_index <= n_key_index;
            r_out_status    <= n_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_key_valid    = r_out_key_valid;
    assign o_key_index    = r_out_key_index;
    assign o_press_status = r_out_status;

    // A reported key only comes with the press status
    a_key_in_press : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_key_valid) |-> (o_press_status == PS_PRESS))
        else $error("key reported outside press");

    // Without a key the index reads zero
    a_idle_index : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_key_valid) |-> (o_key_index == '0))
        else $error("key index set without a key");

    // A reported key is one of the ladder keys
    a_key_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_key_valid) |-> (o_key_index < LVL_KEYS))
        else $error("key index out of range");

    // A new result comes only from a sample held in the input stage
    a_result_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_s1_valid))
        else $error("result without a sample");

endmodule

`default_nettype wire

>>> src/akd_quantizer.sv
// Quantizer that maps one ladder sample to a key level.
`default_nettype none

module akd_quantizer
    import akd_pkg::*;
(
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic [SAMPLE_W-1:0] i_fix_threshold,
    output logic      [LVL_W-1:0]    o_level
);

    localparam logic [PROD_W-1:0] MULT_V = PROD_W'(Q_MULT);
    localparam logic [X_W-1:0]    BIAS_V = X_W'(Q_BIAS);

    logic [X_W-1:0]            w_x;
    logic [PROD_W-1:0]         w_product;
    logic [PROD_W-Q_SHIFT-1:0] w_quot;

    // Bias the sample and divide by the step width
    assign w_x       = {1'b0, i_sample} + BIAS_V;
    assign w_product = PROD_W'(w_x) * MULT_V;
    assign w_quot    = w_product[PROD_W-1:Q_SHIFT];

    // Correct level three for bad resistors, saturate at fifteen
    always_comb begin
        if (w_quot > (PROD_W-Q_SHIFT)'(LVL_MAX)) begin
            o_level = LVL_MAX;
        end else if (w_quot[LVL_W-1:0] == LVL_THREE) begin
            o_level = (i_sample < i_fix_threshold) ? LVL_THREE : LVL_FIX;
        end else begin
            o_level = w_quot[LVL_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the analog ladder keypad decoder unit.
`timescale 1ns / 100ps

module testbench
    import akd_pkg::*;
();

    localparam int CLK_HALF    = 6;
    localparam int RESET_TICKS = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 4;
    localparam int BIN_WIDTH   = ADC_RANGE / 14;
    localparam int BIN_HALF    = ADC_RANGE / 28;

    typedef struct packed {
        logic              key_valid;
        logic [LVL_W-1:0]  key_index;
        logic [STAT_W-1:0] press_status;
    } t_decision;

    // Debounce and touch/press predictor with the queue of decisions due
    class keypad_decision_tracker;
        logic [TGT_W-1:0]    match_target;
        logic [SAMPLE_W-1:0] fix_threshold;
        logic [LVL_W-1:0]    cand_level;
        logic [CNT_W-1:0]    match_count;
        t_touch              touch;
        t_decision           decisions_due[$];
        int                  mismatches;

        function new();
            match_target  = MATCH_TARGET_RST;
            fix_threshold = FIX_THRESHOLD_RST;
            cand_level    = '0;
            match_count   = '0;
            touch         = ST_NONE;
            mismatches    = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_MATCH_TARGET) begin
                match_target = data[TGT_W-1:0];
            end else if (idx == REG_FIX_THRESHOLD) begin
                fix_threshold = data[SAMPLE_W-1:0];
            end
        endfunction

        function logic [LVL_W-1:0] level_of(logic [SAMPLE_W-1:0] s);
            int q;
            q = (int'(s) + BIN_HALF) / BIN_WIDTH;
            // Swap level three for five on the upper part of its band
            if (q == int'(LVL_THREE)) begin
                q = (s < fix_threshold) ? int'(LVL_THREE) : int'(LVL_FIX);
            end
            if (q > int'(LVL_MAX)) begin
                q = int'(LVL_MAX);
            end
            return LVL_W'(q);
        endfunction

        function void take_sample(logic [SAMPLE_W-1:0] s);
            logic [LVL_W-1:0] lvl;
            t_decision        d;
            lvl = level_of(s);
            // Count matches against the candidate, restart on a new level
            if (lvl == cand_level) begin
                if (match_count != CNT_MAX) begin
                    match_count = match_count + 1'b1;
                end
            end else begin
                cand_level  = lvl;
                match_count = '0;
            end
            if (match_count < match_target) begin
                return;
            end
            lvl         = cand_level;
            cand_level  = '0;
            match_count = '0;
            d           = '0;
            // Step the touch/press machine once per decision
            case (touch)
                ST_TOUCH: touch = (lvl < LVL_KEYS) ? ST_PRESS : ST_NONE;
                ST_PRESS: begin
                    if (lvl < LVL_KEYS) begin
                        d.key_valid = 1'b1;
                        d.key_index = lvl;
                    end else begin
                        touch = ST_NONE;
                    end
                end
                default: touch = ST_TOUCH;
            endcase
            case (touch)
                ST_TOUCH: d.press_status = PS_TOUCH;
                ST_PRESS: d.press_status = PS_PRESS;
                default:  d.press_status = PS_NONE;
            endcase
            decisions_due.push_back(d);
        endfunction

        function void check_decision(t_decision got);
            t_decision want;
            if (decisions_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: valid=%0d key=%0d status=%0d",
                             got.key_valid, got.key_index, got.press_status);
                end
                return;
            end
            want = decisions_due.pop_front();
            if (got.key_valid !== want.key_valid || got.key_index !== want.key_index ||
                got.press_status !== want.press_status) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display({"mismatch: expected valid=%0d key=%0d status=%0d, ",
                              "got valid=%0d key=%0d status=%0d"},
                             want.key_valid, want.key_index, want.press_status,
                             got.key_valid, got.key_index, got.press_status);
                end
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_MATCH_TARGET;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [SAMPLE_W-1:0]  i_adc_sample = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_key_valid;
    logic [LVL_W-1:0]     o_key_index;
    logic [STAT_W-1:0]    o_press_status;

    keypad_decision_tracker tracker = new();
    int cycle_count = 0;
    int burst_left = 0;

    analog_ladder_keypad_decoder_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_adc_sample   (i_adc_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_key_valid    (o_key_valid),
        .o_key_index    (o_key_index),
        .o_press_status (o_press_status)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("analog_ladder_keypad_decoder_unit test failed");
            $finish;
        end
    end

    // Check each result transfer, then pick the next stall value
    always @(posedge i_clk) begin
        int mode;
        mode = (cycle_count / 97) % 4;
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.check_decision({o_key_valid, o_key_index, o_press_status});
        end
        case (mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            2:       i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= ((cycle_count % 11) < 6);
        endcase
    end

    // Hold one sample until its transfer
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        i_valid      <= 1'b1;
        i_adc_sample <= s;
        do @(posedge i_clk); while (o_stall);
        tracker.take_sample(s);
    endtask

    // Send with burst gaps on the sender side
    task automatic send_in_bursts(input logic [SAMPLE_W-1:0] s);
        int gap;
        send_sample(s);
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every decision has come back
    task automatic drain();
        i_valid <= 1'b0;
        while (tracker.decisions_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write both registers while idle
    task automatic set_config(input logic [TGT_W-1:0] target,
                              input logic [SAMPLE_W-1:0] threshold);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_MATCH_TARGET;
        i_cfg_data <= CFG_W'(target);
        @(posedge i_clk);
        i_cfg_idx  <= REG_FIX_THRESHOLD;
        i_cfg_data <= CFG_W'(threshold);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_register(REG_MATCH_TARGET, CFG_W'(target));
        tracker.set_register(REG_FIX_THRESHOLD, CFG_W'(threshold));
    endtask

    function automatic logic [SAMPLE_W-1:0] sample_in_band(int band);
        int lo;
        int hi;
        lo = band * BIN_WIDTH - BIN_HALF;
        hi = band * BIN_WIDTH + BIN_HALF;
        if (lo < 0) lo = 0;
        if (hi > ADC_RANGE - 1) hi = ADC_RANGE - 1;
        // Keep a level-three sample on one side of the threshold half the time
        if (band == int'(LVL_THREE) && $urandom_range(0, 1) == 1) begin
            if ($urandom_range(0, 1) == 1 && int'(tracker.fix_threshold) > lo &&
                int'(tracker.fix_threshold) <= hi) begin
                hi = int'(tracker.fix_threshold) - 1;
            end else if (int'(tracker.fix_threshold) > lo &&
                         int'(tracker.fix_threshold) <= hi) begin
                lo = int'(tracker.fix_threshold);
            end
        end
        return SAMPLE_W'($urandom_range(lo, hi));
    endfunction

    // Mostly runs of one level with random content, some raw noise
    task automatic random_phase(input logic [TGT_W-1:0] target,
                                input logic [SAMPLE_W-1:0] threshold, input int count);
        int sent;
        int band;
        int run;
        sent = 0;
        set_config(target, threshold);
        while (sent < count) begin
            if ($urandom_range(0, 99) < 85) begin
                band = $urandom_range(0, KEY_COUNT);
                run  = $urandom_range(1, int'(target) + 3);
                repeat (run) begin
                    send_in_bursts(sample_in_band(band));
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    send_in_bursts(SAMPLE_W'($urandom_range(0, ADC_RANGE - 1)));
                    sent++;
                end
            end
        end
        drain();
    endtask

    initial begin
        repeat (RESET_TICKS) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: level zero matches at once, full scale releases
        repeat (5) send_sample('0);
        repeat (6) send_sample('1);
        drain();

        // Decide on the second sample of a level, at once for level zero: walk the threshold split and the key extremes
        set_config(3'd1, FIX_THRESHOLD_RST);
        repeat (2) send_sample(10'd231);
        repeat (2) send_sample(10'd232);
        repeat (2) send_sample(10'd255);
        repeat (2) send_sample(10'd183);
        repeat (2) send_sample(10'd985);
        repeat (2) send_sample(10'd36);
        repeat (2) send_sample(10'd986);
        drain();

        random_phase(3'd7, 10'd0, 110);
        random_phase(3'd1, 10'd1023, 110);
        random_phase(3'd3, FIX_THRESHOLD_RST, 110);
        random_phase(3'd0, SAMPLE_W'($urandom_range(0, ADC_RANGE - 1)), 50);
        random_phase(3'd2, SAMPLE_W'($urandom_range(0, ADC_RANGE - 1)), 110);
        random_phase(3'd7, 10'd1023, 110);
        random_phase(3'd4, 10'd183, 110);
        random_phase(3'd6, 10'd256, 110);
        random_phase(TGT_W'($urandom_range(1, 7)),
                     SAMPLE_W'($urandom_range(0, ADC_RANGE - 1)), 110);
        random_phase(MATCH_TARGET_RST, FIX_THRESHOLD_RST, 100);

        repeat (8) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.decisions_due.size() == 0) begin
            $display("analog_ladder_keypad_decoder_unit test passed");
        end else begin
            $display("analog_ladder_keypad_decoder_unit test failed");
        end
        $finish;
    end

endmodule
